/* sv/tcf_pkg.sv */
package tcf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam int VALUE_W = 32;

    // request opcodes
    localparam logic [1:0] OP_ENQ     = 2'd0;
    localparam logic [1:0] OP_DEQ_DOG = 2'd1;
    localparam logic [1:0] OP_DEQ_CAT = 2'd2;
    localparam logic [1:0] OP_DEQ_ANY = 2'd3;

    // result status codes
    localparam logic [1:0] ST_POPPED   = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_ENQUEUED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic CLS_DOG = 1'b0;
    localparam logic CLS_CAT = 1'b1;

    // decoded command kinds between front and back
    localparam logic [2:0] CMD_ENQ_DOG = 3'd0;
    localparam logic [2:0] CMD_ENQ_CAT = 3'd1;
    localparam logic [2:0] CMD_DEQ_DOG = 3'd2;
    localparam logic [2:0] CMD_DEQ_CAT = 3'd3;
    localparam logic [2:0] CMD_DEQ_ANY = 3'd4;

    typedef struct packed {
        logic [2:0]                kind;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

endpackage

/* sv/tcf_front.sv */
module tcf_front
    import tcf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                operation,
    input  logic signed [VALUE_W-1:0] item_value,
    input  logic                      item_class,
    output cmd_t                      cmd,
    output logic                      cmd_valid,
    input  logic                      cmd_ready
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       dec;
    logic       push, pop;

    always_comb
    begin
        dec.value = item_value;
        unique case (operation)
            OP_ENQ:     dec.kind = (item_class == CLS_CAT) ? CMD_ENQ_CAT : CMD_ENQ_DOG;
            OP_DEQ_DOG: dec.kind = CMD_DEQ_DOG;
            OP_DEQ_CAT: dec.kind = CMD_DEQ_CAT;
            OP_DEQ_ANY: dec.kind = CMD_DEQ_ANY;
            default:    dec.kind = CMD_DEQ_ANY;
        endcase
    end

    assign in_stall  = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

/* sv/tcf_back.sv */
module tcf_back
    import tcf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic signed [VALUE_W-1:0] out_value,
    output logic                      out_class
);

    logic signed [VALUE_W-1:0] mem_reg [2][QUEUE_DEPTH];
    logic [PTR_W-1:0]          head_reg [2];
    logic [PTR_W-1:0]          head_next [2];
    logic [CNT_W-1:0]          count_reg [2];
    logic [CNT_W-1:0]          count_next [2];
    logic [PTR_W-1:0]          tail [2];
    logic [SUM_W-1:0]          tail_sum [2];
    logic signed [VALUE_W-1:0] head_val [2];
    logic                      empty [2];
    logic                      full [2];

    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                status_reg, status_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic                      class_reg, class_next;

    logic                      go;
    logic                      push_en, pop_en;
    logic                      push_cls, pop_cls;

    assign go        = cmd_valid && (!out_valid_reg || !out_stall);
    assign cmd_ready = go;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            empty[c]    = (count_reg[c] == '0);
            full[c]     = (count_reg[c] == CNT_W'(QUEUE_DEPTH));
            head_val[c] = mem_reg[c][head_reg[c]];
            tail_sum[c] = SUM_W'(head_reg[c]) + SUM_W'(count_reg[c]);
            if (tail_sum[c] >= SUM_W'(QUEUE_DEPTH))
            begin
                tail_sum[c] = tail_sum[c] - SUM_W'(QUEUE_DEPTH);
            end
            tail[c] = tail_sum[c][PTR_W-1:0];
        end
    end

    // command execution
    always_comb
    begin
        push_en  = 1'b0;
        push_cls = CLS_DOG;
        pop_en   = 1'b0;
        pop_cls  = CLS_DOG;
        unique case (cmd.kind) inside
            CMD_ENQ_DOG, CMD_ENQ_CAT:
            begin
                push_cls = (cmd.kind == CMD_ENQ_CAT);
                push_en  = go && !full[push_cls];
            end
            CMD_DEQ_DOG:
            begin
                pop_cls = CLS_DOG;
                pop_en  = go && !empty[CLS_DOG];
            end
            CMD_DEQ_CAT:
            begin
                pop_cls = CLS_CAT;
                pop_en  = go && !empty[CLS_CAT];
            end
            CMD_DEQ_ANY:
            begin
                // smaller key wins, tie goes to dog
                if (!empty[CLS_DOG] && !empty[CLS_CAT])
                begin
                    pop_cls = (head_val[CLS_DOG] > head_val[CLS_CAT]);
                end
                else
                begin
                    pop_cls = empty[CLS_DOG];
                end
                pop_en = go && !(empty[CLS_DOG] && empty[CLS_CAT]);
            end
            default:
            begin
                pop_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            head_next[c]  = head_reg[c];
            count_next[c] = count_reg[c];
            if (pop_en && (pop_cls == c[0]))
            begin
                head_next[c]  = (head_reg[c] == PTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : head_reg[c] + PTR_W'(1);
                count_next[c] = count_reg[c] - CNT_W'(1);
            end
            if (push_en && (push_cls == c[0]))
            begin
                count_next[c] = count_reg[c] + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        value_next     = value_reg;
        class_next     = class_reg;
        if (go)
        begin
            out_valid_next = 1'b1;
            value_next     = '0;
            class_next     = CLS_DOG;
            if (pop_en)
            begin
                status_next = ST_POPPED;
                value_next  = head_val[pop_cls];
                class_next  = pop_cls;
            end
            else if (cmd.kind == CMD_ENQ_DOG || cmd.kind == CMD_ENQ_CAT)
            begin
                status_next = push_en ? ST_ENQUEUED : ST_FULL;
            end
            else
            begin
                status_next = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int c = 0; c < 2; c++)
            begin
                head_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < 2; c++)
            begin
                head_reg[c]  <= head_next[c];
                count_reg[c] <= count_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        class_reg  <= class_next;
        if (push_en)
        begin
            mem_reg[push_cls][tail[push_cls]] <= cmd.value;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_value = value_reg;
    assign out_class = class_reg;

endmodule

/* sv/two_class_fifo_oldest_first.sv */
// Two-class queue: one FIFO of signed 32-bit keys per class
// (0 dog, 1 cat), QUEUE_DEPTH entries each.
// Request channel: in_valid/in_stall with operation, item_value, item_class.
//   operation 0 enqueues item_value into item_class, 1/2 pop dog/cat,
//   3 pops the head with the smaller key (tie to dog).
// Result channel: out_valid/out_stall with status, out_value, out_class.
//   Every request gives exactly one result, in request order.
// A two-entry command queue decouples the decoder from the execute stage.
// A request is written into the command queue and then executed into the
// result register. Throughput: one request per cycle while out_stall is low,
// set by the execute stage (head read, signed compare, pointer update).
// Reset empties both class queues and the command queue; no clearing pass.
// When out_stall is held with out_valid high, the result register holds, execute
// stops, and in_stall rises once the command queue holds two requests.
module two_class_fifo_oldest_first
    import tcf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                operation,
    input  logic signed [VALUE_W-1:0] item_value,
    input  logic                      item_class,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic signed [VALUE_W-1:0] out_value,
    output logic                      out_class
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    tcf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .item_value (item_value),
        .item_class (item_class),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready)
    );

    tcf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .out_value  (out_value),
        .out_class  (out_class)
    );

`ifndef SYNTHESIS
    a_nonpop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_POPPED) |-> (out_value == '0 && out_class == CLS_DOG))
        else $error("non-pop result carries a value");

    a_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_ready) |=> (cmd_valid && $stable(cmd)))
        else $error("pending command lost or changed");

    a_exec_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd_ready)
        else $error("command executed while result stalled");
`endif

endmodule
